[src/mdef_pkg.sv]
package mdef_pkg;

  localparam int GRID_WIDTH  = 32;
  localparam int GRID_HEIGHT = 32;

  localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W      = $clog2(CELL_COUNT);
  localparam int X_W         = $clog2(GRID_WIDTH);
  localparam int Y_W         = $clog2(GRID_HEIGHT);
  localparam int REPORT_ROWS = (GRID_HEIGHT < 32) ? GRID_HEIGHT : 32;
  localparam int REPORT_COLS = (GRID_WIDTH < 32) ? GRID_WIDTH : 32;

  localparam logic [3:0] WALL_N     = 4'h1;
  localparam logic [3:0] WALL_E     = 4'h2;
  localparam logic [3:0] WALL_S     = 4'h4;
  localparam logic [3:0] WALL_W     = 4'h8;
  localparam logic [3:0] WALLS_SHUT = 4'hF;

  // Stored cell: path mark in bit 4, walls in bits 3..0
  typedef logic [4:0] cell_t;

  typedef struct packed {
    logic [3:0] walls;
    logic       last_cell;
  } mdef_in_t;

  typedef struct packed {
    logic [4:0]  row_index;
    logic [31:0] path_bits;
    logic        last_row;
  } mdef_out_t;

  typedef enum logic [1:0] {
    ALU_LOAD,
    ALU_INIT,
    ALU_FILL,
    ALU_OR
  } alu_op_t;

  typedef enum logic [1:0] {
    NB_SOUTH,
    NB_WEST,
    NB_NORTH,
    NB_EAST
  } nb_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_RD,
    S_INIT_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_NB_RD,
    S_NB_WR,
    S_OUT_RD,
    S_OUT_CAP,
    S_OUT_EMIT
  } state_t;

endpackage

[src/mdef_store.sv]
module mdef_store
  import mdef_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  cell_t             wdata,
  input  logic [ADDR_W-1:0] raddr,
  output cell_t             rdata
);

  cell_t mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/mdef_cell_alu.sv]
module mdef_cell_alu
  import mdef_pkg::*;
(
  input  alu_op_t    op,
  input  cell_t      cell_in,
  input  logic [3:0] walls,
  input  logic [3:0] mask,
  input  logic       is_first,
  input  logic       is_last,
  output cell_t      cell_out,
  output logic       dead_end
);

  logic [3:0] init_walls;

  always_comb begin
    init_walls = cell_in[3:0];
    if (is_first) begin
      init_walls = init_walls & ~WALL_N;
    end
    if (is_last) begin
      init_walls = init_walls & ~WALL_S;
    end
  end

  always_comb begin
    case (op)
      ALU_LOAD: cell_out = {1'b0, walls};
      ALU_INIT: cell_out = {1'b1, init_walls};
      ALU_FILL: cell_out = {1'b0, WALLS_SHUT};
      ALU_OR:   cell_out = cell_in | {1'b0, mask};
      default:  cell_out = cell_in;
    endcase
  end

  assign dead_end = ($countones(cell_in[3:0]) == 3);

endmodule

[src/maze_dead_end_filler_unit.sv]
// Dead-end filling maze solver.
// Load side: present one cell per transaction on item (walls: bit0 north,
// bit1 east, bit2 south, bit3 west) with start high; a transaction completes
// at a clock edge with start high and busy low. Cells go in row-major order.
// The cell with last_cell set is stored and then starts the solve; busy
// stays high until the last row has been reported.
// Solve: open the entrance and exit and mark every cell, then sweep all
// cells, filling every dead end found (read-modify-write of the cell and
// its neighbours through the store's one read and one write port). Sweeps
// repeat until one finds no dead end.
// Report: one transaction per row on result, each shown for one cycle with
// strobe high, top row first.
// The receiver cannot stall; results are simply presented.
// Reset returns to idle and the load position to the first cell; the cell
// store itself is not cleared.
module maze_dead_end_filler_unit
  import mdef_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  mdef_in_t  item,
  output mdef_out_t result,
  output logic      strobe
);

  localparam logic [ADDR_W-1:0] IDX_LAST = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(GRID_WIDTH);
  localparam logic [X_W-1:0]    X_LAST   = X_W'(GRID_WIDTH - 1);
  localparam logic [Y_W-1:0]    Y_LAST   = Y_W'(GRID_HEIGHT - 1);
  localparam logic [X_W-1:0]    COL_LAST = X_W'(REPORT_COLS - 1);
  localparam logic [Y_W-1:0]    ROW_LAST = Y_W'(REPORT_ROWS - 1);

  state_t            state, state_next;
  logic [ADDR_W-1:0] load_index, load_index_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [ADDR_W-1:0] row_base, row_base_next;
  logic [X_W-1:0]    x, x_next;
  logic [Y_W-1:0]    y, y_next;
  nb_t               nb, nb_next;
  logic              found, found_next;
  logic [31:0]       row_bits, row_bits_next;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  cell_t             mem_rdata;
  cell_t             alu_out;
  alu_op_t           alu_op;
  logic [3:0]        alu_mask;
  logic              alu_dead;

  logic [ADDR_W-1:0] nb_addr;
  logic [3:0]        nb_mask;
  logic              nb_ok;
  logic              step_cell;

  mdef_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (alu_out),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mdef_cell_alu u_alu (
    .op       (alu_op),
    .cell_in  (mem_rdata),
    .walls    (item.walls),
    .mask     (alu_mask),
    .is_first (idx == '0),
    .is_last  (idx == IDX_LAST),
    .cell_out (alu_out),
    .dead_end (alu_dead)
  );

  // Neighbour under update and the wall it gains
  always_comb begin
    case (nb)
      NB_SOUTH: begin
        nb_addr = idx + ROW_STEP;
        nb_mask = WALL_N;
        nb_ok   = (y != Y_LAST);
      end
      NB_WEST: begin
        nb_addr = idx - 1'b1;
        nb_mask = WALL_E;
        nb_ok   = (x != '0);
      end
      NB_NORTH: begin
        nb_addr = idx - ROW_STEP;
        nb_mask = WALL_S;
        nb_ok   = (y != '0);
      end
      NB_EAST: begin
        nb_addr = idx + 1'b1;
        nb_mask = WALL_W;
        nb_ok   = (x != X_LAST);
      end
      default: begin
        nb_addr = idx;
        nb_mask = '0;
        nb_ok   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      load_index <= '0;
      found      <= 1'b0;
    end else begin
      state      <= state_next;
      load_index <= load_index_next;
      found      <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    row_base <= row_base_next;
    x        <= x_next;
    y        <= y_next;
    nb       <= nb_next;
    row_bits <= row_bits_next;
  end

  always_comb begin
    state_next      = state;
    load_index_next = load_index;
    idx_next        = idx;
    row_base_next   = row_base;
    x_next          = x;
    y_next          = y;
    nb_next         = nb;
    found_next      = found;
    row_bits_next   = row_bits;
    mem_we          = 1'b0;
    mem_waddr       = idx;
    mem_raddr       = idx;
    alu_op          = ALU_LOAD;
    alu_mask        = '0;
    step_cell       = 1'b0;
    strobe          = 1'b0;

    case (state)
      S_IDLE: begin
        mem_waddr = load_index;
        if (start) begin
          mem_we          = 1'b1;
          load_index_next = (load_index == IDX_LAST) ? '0 : load_index + 1'b1;
          if (item.last_cell) begin
            load_index_next = '0;
            idx_next        = '0;
            state_next      = S_INIT_RD;
          end
        end
      end
      S_INIT_RD: begin
        state_next = S_INIT_WR;
      end
      S_INIT_WR: begin
        alu_op = ALU_INIT;
        mem_we = 1'b1;
        if (idx == IDX_LAST) begin
          idx_next   = '0;
          x_next     = '0;
          y_next     = '0;
          found_next = 1'b0;
          state_next = S_SCAN_RD;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_INIT_RD;
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        alu_op = ALU_FILL;
        if (alu_dead) begin
          mem_we     = 1'b1;
          found_next = 1'b1;
          nb_next    = NB_SOUTH;
          state_next = S_NB_RD;
        end else begin
          step_cell = 1'b1;
        end
      end
      S_NB_RD: begin
        mem_raddr = nb_addr;
        if (nb_ok) begin
          state_next = S_NB_WR;
        end else if (nb == NB_EAST) begin
          step_cell = 1'b1;
        end else begin
          nb_next = nb_t'(2'(nb) + 2'd1);
        end
      end
      S_NB_WR: begin
        alu_op    = ALU_OR;
        alu_mask  = nb_mask;
        mem_we    = 1'b1;
        mem_waddr = nb_addr;
        if (nb == NB_EAST) begin
          step_cell = 1'b1;
        end else begin
          nb_next    = nb_t'(2'(nb) + 2'd1);
          state_next = S_NB_RD;
        end
      end
      S_OUT_RD: begin
        mem_raddr  = row_base + ADDR_W'(x);
        state_next = S_OUT_CAP;
      end
      S_OUT_CAP: begin
        row_bits_next = {mem_rdata[4], row_bits[31:1]};
        if (x == COL_LAST) begin
          state_next = S_OUT_EMIT;
        end else begin
          x_next     = x + 1'b1;
          state_next = S_OUT_RD;
        end
      end
      S_OUT_EMIT: begin
        strobe = 1'b1;
        x_next = '0;
        if (y == ROW_LAST) begin
          state_next = S_IDLE;
        end else begin
          y_next        = y + 1'b1;
          row_base_next = row_base + ROW_STEP;
          state_next    = S_OUT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Advance to the next cell, or close the sweep
    if (step_cell) begin
      if (idx == IDX_LAST) begin
        idx_next = '0;
        x_next   = '0;
        y_next   = '0;
        if (found) begin
          found_next = 1'b0;
          state_next = S_SCAN_RD;
        end else begin
          row_base_next = '0;
          state_next    = S_OUT_RD;
        end
      end else begin
        idx_next   = idx + 1'b1;
        state_next = S_SCAN_RD;
        if (x == X_LAST) begin
          x_next = '0;
          y_next = y + 1'b1;
        end else begin
          x_next = x + 1'b1;
        end
      end
    end
  end

  assign busy             = (state != S_IDLE);
  assign result.row_index = 5'(y);
  assign result.path_bits = row_bits >> (32 - REPORT_COLS);
  assign result.last_row  = (y == ROW_LAST);

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result strobe outside a solve");

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last_cell) |=> busy)
    else $error("last cell did not start the solve");

  a_last_row_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last_row) |=> !busy)
    else $error("block still busy after the bottom row");

  a_nb_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_NB_WR) |-> found)
    else $error("neighbour update without a dead end in the sweep");

endmodule
